[hdl/key_matrix_midi_note_events_assert.svh]
// Assertion macros of the key matrix MIDI note event port checker
`ifndef KEY_MATRIX_MIDI_NOTE_EVENTS_ASSERT_SVH
`define KEY_MATRIX_MIDI_NOTE_EVENTS_ASSERT_SVH

// Check on every rising clock edge outside reset
`define KMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising clock edge, reset included
`define KMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/kmm_pkg.sv]
// Shared types and constants of the key matrix MIDI note event block
`default_nettype none

package kmm_pkg;

  localparam int unsigned DEF_COLUMN_COUNT = 8;
  localparam int unsigned DEF_ROW_COUNT    = 4;

  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [7:0] STATUS_ON  = 8'h90;
  localparam logic [7:0] STATUS_OFF = 8'h80;
  localparam logic [6:0] DATA_MAX   = 7'd127;

  localparam logic [6:0] BASE_NOTE_RESET = 7'd48;
  localparam logic [6:0] VELOCITY_RESET  = 7'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_NOTE     = 1'b0,
    REG_NOTE_VELOCITY = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

[hdl/key_matrix_midi_note_events.sv]
// Top level of the key matrix scanner to MIDI note event block
// Each transfer on the input carries one scanned column. The key state is
// compared and updated in the cycle of the transfer; every key of that column
// whose state changed then yields three bytes (status, pitch, velocity),
// sent one byte a cycle while the output is not stalled, through a single
// output register, the final one marked. A column with no change, or beyond
// COLUMN_COUNT, does not hold the input and yields nothing. A column with k
// changed keys yields 3*k bytes, at most 3*ROW_COUNT (12 at the default
// sizes); the next column is taken in the cycle its predecessor's last byte
// enters the output register, so a stalled full output register delays it.
`default_nettype none

module key_matrix_midi_note_events import kmm_pkg::*; #(
  parameter int unsigned COLUMN_COUNT = DEF_COLUMN_COUNT,
  parameter int unsigned ROW_COUNT    = DEF_ROW_COUNT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [2:0]            column_i,
  input  wire logic [3:0]            row_levels_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 midi_byte_o,
  output logic                       last_byte_o
);

  localparam int unsigned ColW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

  logic                 in_accept;
  logic                 in_range;
  logic [ColW-1:0]      col_idx;
  logic [ROW_COUNT-1:0] change;
  logic [ROW_COUNT-1:0] press;
  logic                 busy;

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  kmm_key_state #(
    .COLUMN_COUNT (COLUMN_COUNT),
    .ROW_COUNT    (ROW_COUNT)
  ) u_key_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .column_i     (column_i),
    .row_levels_i (row_levels_i),
    .update_i     (in_accept),
    .in_range_o   (in_range),
    .col_idx_o    (col_idx),
    .change_o     (change),
    .press_o      (press)
  );

  kmm_emit #(
    .COLUMN_COUNT (COLUMN_COUNT),
    .ROW_COUNT    (ROW_COUNT)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .load_i      (in_accept && in_range && (|change)),
    .col_i       (col_idx),
    .mask_i      (change),
    .press_i     (press),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .midi_byte_o (midi_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

`default_nettype wire

[hdl/kmm_key_state.sv]
// Pressed state of every key and change detection for one scanned column
`default_nettype none

module kmm_key_state import kmm_pkg::*; #(
  parameter int unsigned COLUMN_COUNT = DEF_COLUMN_COUNT,
  parameter int unsigned ROW_COUNT    = DEF_ROW_COUNT,
  localparam int unsigned ColW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [2:0]           column_i,
  input  wire logic [3:0]           row_levels_i,
  input  wire logic                 update_i,
  output logic                      in_range_o,
  output logic [ColW-1:0]           col_idx_o,
  output logic [ROW_COUNT-1:0]      change_o,
  output logic [ROW_COUNT-1:0]      press_o
);

  localparam int unsigned LvlW = (ROW_COUNT > 4) ? ROW_COUNT : 4;
  localparam int unsigned ExtW = ColW + 3;

  logic [COLUMN_COUNT-1:0] key_q [ROW_COUNT];
  logic [ExtW-1:0]         col_ext;
  logic [LvlW-1:0]         levels;

  assign col_ext    = ExtW'(column_i);
  assign col_idx_o  = col_ext[ColW-1:0];
  assign in_range_o = col_ext < ExtW'(COLUMN_COUNT);
  assign levels     = LvlW'(row_levels_i);

  always_comb begin
    for (int r = 0; r < ROW_COUNT; r++) begin
      press_o[r]  = ~levels[r];
      change_o[r] = in_range_o && (press_o[r] != key_q[r][col_idx_o]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        key_q[r] <= '0;
      end
    end else if (update_i && in_range_o) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        key_q[r][col_idx_o] <= press_o[r];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/kmm_emit.sv]
// Event register and byte serialiser with registered MIDI output
`default_nettype none

module kmm_emit import kmm_pkg::*; #(
  parameter int unsigned COLUMN_COUNT = DEF_COLUMN_COUNT,
  parameter int unsigned ROW_COUNT    = DEF_ROW_COUNT,
  localparam int unsigned ColW = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  load_i,
  input  wire logic [ColW-1:0]       col_i,
  input  wire logic [ROW_COUNT-1:0]  mask_i,
  input  wire logic [ROW_COUNT-1:0]  press_i,
  output logic                       busy_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 midi_byte_o,
  output logic                       last_byte_o
);

  localparam int unsigned RowW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned NoteW = 9;

  typedef enum logic [2:0] {
    PH_STATUS = 3'b001,
    PH_PITCH  = 3'b010,
    PH_VEL    = 3'b100
  } phase_e;

  logic [6:0]           base_q;
  logic [6:0]           vel_q;
  logic                 ev_valid_q;
  logic [ColW-1:0]      ev_col_q;
  logic [ROW_COUNT-1:0] ev_mask_q;
  logic [ROW_COUNT-1:0] ev_press_q;
  phase_e               phase_q;
  phase_e               phase_d;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 out_last_q;

  logic [RowW-1:0]      row_sel;
  logic [ROW_COUNT-1:0] row_bit;
  logic                 only_one;
  logic                 step;
  logic                 ev_done;
  logic [NoteW-1:0]     note_sum;
  logic [6:0]           pitch;
  logic [7:0]           byte_d;

  always_comb begin
    row_sel = '0;
    for (int r = ROW_COUNT - 1; r >= 0; r--) begin
      if (ev_mask_q[r]) begin
        row_sel = RowW'(r);
      end
    end
  end

  always_comb begin
    row_bit = '0;
    row_bit[row_sel] = 1'b1;
  end

  assign only_one = (ev_mask_q & ~row_bit) == '0;
  assign step     = ev_valid_q && (!out_valid_q || !out_stall_i);
  assign ev_done  = step && (phase_q == PH_VEL) && only_one;
  assign busy_o   = ev_valid_q && !ev_done;

  assign note_sum = NoteW'(base_q) + NoteW'(ev_col_q)
                  + NoteW'(COLUMN_COUNT) * NoteW'(row_sel);
  assign pitch    = (note_sum > NoteW'(DATA_MAX)) ? DATA_MAX : note_sum[6:0];

  always_comb begin
    unique case (phase_q)
      PH_STATUS: begin
        byte_d  = ev_press_q[row_sel] ? STATUS_ON : STATUS_OFF;
        phase_d = PH_PITCH;
      end
      PH_PITCH: begin
        byte_d  = {1'b0, pitch};
        phase_d = PH_VEL;
      end
      PH_VEL: begin
        byte_d  = {1'b0, vel_q};
        phase_d = PH_STATUS;
      end
      default: begin
        byte_d  = {1'b0, vel_q};
        phase_d = PH_STATUS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_NOTE_RESET;
      vel_q  <= VELOCITY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BASE_NOTE:     base_q <= cfg_data_i;
        REG_NOTE_VELOCITY: vel_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
      phase_q    <= PH_STATUS;
    end else if (load_i) begin
      ev_valid_q <= 1'b1;
      phase_q    <= PH_STATUS;
    end else if (ev_done) begin
      ev_valid_q <= 1'b0;
      phase_q    <= PH_STATUS;
    end else if (step) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev_col_q   <= col_i;
      ev_mask_q  <= mask_i;
      ev_press_q <= press_i;
    end else if (step && (phase_q == PH_VEL)) begin
      ev_mask_q <= ev_mask_q & ~row_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= byte_d;
      out_last_q <= (phase_q == PH_VEL) && only_one;
    end
  end

  assign out_valid_o = out_valid_q;
  assign midi_byte_o = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

`default_nettype wire

[hdl/kmm_checker.sv]
// Port-level checks of the key matrix MIDI note event block
`default_nettype none

`include "key_matrix_midi_note_events_assert.svh"

module kmm_checker import kmm_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] midi_byte_o,
  input wire logic       last_byte_o
);

  logic [1:0] pos_q;
  logic       out_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (out_xfer) begin
      pos_q <= (pos_q == 2'd2) ? 2'd0 : pos_q + 2'd1;
    end
  end

  `KMM_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !out_valid_o, "output valid during reset")
  `KMM_ASSERT(a_hold_stalled, out_valid_o && out_stall_i |=> out_valid_o && $stable(midi_byte_o) && $stable(last_byte_o), "stalled output changed")
  `KMM_ASSERT(a_status_first, out_valid_o && (pos_q == 2'd0) |-> (midi_byte_o == STATUS_ON) || (midi_byte_o == STATUS_OFF), "message does not open with a note status")
  `KMM_ASSERT(a_data_bytes, out_valid_o && (pos_q != 2'd0) |-> !midi_byte_o[7] && (!last_byte_o || (pos_q == 2'd2)), "bad data byte or misplaced last mark")

endmodule

bind key_matrix_midi_note_events kmm_checker u_kmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .midi_byte_o (midi_byte_o),
  .last_byte_o (last_byte_o)
);

`default_nettype wire

[tb/key_matrix_midi_note_events_checker.sv]
// Checker for the key matrix MIDI note event block: predicts note bytes and compares them
module key_matrix_midi_note_events_checker import kmm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [2:0]            column_i,
  input  logic [3:0]            row_levels_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            midi_byte_i,
  input  logic                  last_byte_i,
  output int                    mismatch_count_o,
  output int                    bytes_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLUMNS = DEF_COLUMN_COUNT;
  localparam int unsigned ROWS    = DEF_ROW_COUNT;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } note_byte_t;

  note_byte_t                  note_bytes_due[$];
  logic [COLUMNS*ROWS-1:0]     keys_held;
  logic [6:0]                  base_note_q;
  logic [6:0]                  velocity_q;

  task automatic predict_scan(input logic [2:0] col, input logic [3:0] levels);
    note_byte_t message[$];
    int         key;
    int         pitch;
    logic       pressed;
    if (col >= COLUMNS) return;
    for (int r = 0; r < ROWS; r++) begin
      key     = col + COLUMNS * r;
      pressed = (r < 4) ? !levels[r] : 1'b1;
      if (key < COLUMNS * ROWS && pressed != keys_held[key]) begin
        keys_held[key] = pressed;
        pitch = base_note_q + key;
        if (pitch > DATA_MAX) pitch = DATA_MAX;
        message.push_back('{pressed ? STATUS_ON : STATUS_OFF, 1'b0});
        message.push_back('{8'(pitch), 1'b0});
        message.push_back('{{1'b0, velocity_q}, 1'b0});
      end
    end
    if (message.size() > 0) message[message.size()-1].last = 1'b1;
    foreach (message[i]) note_bytes_due.push_back(message[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    note_byte_t due;
    if (!rst_ni) begin
      note_bytes_due.delete();
      keys_held        = '0;
      base_note_q      = BASE_NOTE_RESET;
      velocity_q       = VELOCITY_RESET;
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (note_bytes_due.size() == 0) begin
          $display("%0t: unexpected byte %02h last %0b", $time, midi_byte_i, last_byte_i);
          mismatch_count_o++;
        end else begin
          due = note_bytes_due.pop_front();
          if (midi_byte_i !== due.value) begin
            $display("%0t: midi_byte expected %02h actual %02h", $time, due.value,
                     midi_byte_i);
            mismatch_count_o++;
          end
          if (last_byte_i !== due.last) begin
            $display("%0t: last_byte expected %0b actual %0b", $time, due.last,
                     last_byte_i);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_BASE_NOTE:     base_note_q = cfg_data_i;
          REG_NOTE_VELOCITY: velocity_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_scan(column_i, row_levels_i);
    end
    bytes_due_o = note_bytes_due.size();
  end

endmodule

[tb/key_matrix_midi_note_events_tb.sv]
// Testbench top for the key matrix MIDI note event block: stimulus, stalls and verdict
module key_matrix_midi_note_events_tb import kmm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            column = '0;
  logic [3:0]            row_levels = '1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            midi_byte;
  logic                  last_byte;
  logic                  quiet = 1'b0;
  int                    mismatch_count;
  int                    bytes_due;
  int                    idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  key_matrix_midi_note_events u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .column_i     (column),
    .row_levels_i (row_levels),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .midi_byte_o  (midi_byte),
    .last_byte_o  (last_byte)
  );

  key_matrix_midi_note_events_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .column_i         (column),
    .row_levels_i     (row_levels),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .midi_byte_i      (midi_byte),
    .last_byte_i      (last_byte),
    .mismatch_count_o (mismatch_count),
    .bytes_due_o      (bytes_due)
  );

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver stalls in runs of random length
  initial begin : stall_driver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_stall = 1'b0;
        hold      = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        out_stall = ($urandom_range(0, 2) == 0);
        hold      = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_scan(input logic [2:0] col, input logic [3:0] levels);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid   = 1'b1;
    column     = col;
    row_levels = levels;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic wait_all_bytes();
    in_valid = 1'b0;
    while (bytes_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [6:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic set_voicing(input logic [6:0] base, input logic [6:0] velocity);
    wait_all_bytes();
    write_reg(REG_BASE_NOTE, base);
    write_reg(REG_NOTE_VELOCITY, velocity);
  endtask

  function automatic logic [3:0] pick_levels();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 4'h0;
    if (r < 30) return 4'hF;
    return 4'($urandom_range(0, 15));
  endfunction

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset voicing
    send_scan(3'd0, 4'hF);
    send_scan(3'd0, 4'h0);
    send_scan(3'd0, 4'h0);
    send_scan(3'd7, 4'h0);
    send_scan(3'd7, 4'b1010);
    send_scan(3'd3, 4'b0110);
    send_scan(3'd0, 4'hF);
    send_scan(3'd7, 4'hF);
    send_scan(3'd3, 4'hF);

    set_voicing(7'd0, 7'd0);
    send_scan(3'd0, 4'b1110);
    send_scan(3'd5, 4'h0);
    send_scan(3'd0, 4'hF);
    send_scan(3'd5, 4'hF);

    set_voicing(7'd96, 7'd1);
    send_scan(3'd7, 4'h0);
    send_scan(3'd7, 4'hF);

    // pitch saturates
    set_voicing(7'd127, 7'd127);
    send_scan(3'd1, 4'h0);
    send_scan(3'd6, 4'b1100);
    send_scan(3'd1, 4'hF);
    send_scan(3'd6, 4'hF);

    set_voicing(7'd100, 7'd85);
    send_scan(3'd4, 4'h0);
    send_scan(3'd4, 4'hF);

    for (int phase = 0; phase < 4; phase++) begin
      set_voicing(($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 96))
                                              : 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
      quiet = (phase == 2);
      for (int n = 0; n < 25; n++) send_scan(3'($urandom_range(0, 7)), pick_levels());
      quiet = 1'b0;
    end

    wait_all_bytes();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
